// ----- sv/lcabl_pkg.sv -----
// Shared types and constants for the binary-lifting common-ancestor block.
// Used by lcabl_ctrl, lcabl_dpath and tree_lca_binary_lifting.
`timescale 1ns / 1ps

package lcabl_pkg;

  // Field widths and stream widths
  localparam int NODE_W = 10;
  localparam int STAT_W = 2;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 16;

  // Parameter defaults
  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;

  localparam logic [NODE_W-1:0] DEPTH_MAX = 10'd1023;

  // Opcodes
  localparam logic OPC_LOAD  = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_PARENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_QUERY  = 2'd2;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_LD_CHK,
    OP_LD_FILL,
    OP_LD_WR,
    OP_Q_CHK,
    OP_LIFT,
    OP_LIFT_WT,
    OP_Q_CMP,
    OP_CLIMB,
    OP_FIN,
    OP_EMIT
  } dp_op_t;

  // Level counter control
  typedef enum logic [2:0] {
    LV_HOLD,
    LV_TOP,
    LV_ONE,
    LV_ZERO,
    LV_INC,
    LV_DEC
  } lvl_ctl_t;

  typedef struct packed {
    dp_op_t   op;
    lvl_ctl_t lvl;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass at last entry
    logic in_query;   // opcode of the item offered at the input
    logic ld_skip;    // load names node zero or out of range
    logic ld_bad;     // load parent not loaded
    logic q_bad;      // query node not loaded
    logic lift_need;  // remaining depth gap covers the current level
    logic lvl_zero;
    logic lvl_last;
    logic uv_eq;
    logic out_free;   // output register can take a result
  } dp_stat_t;

endpackage

// ----- sv/lcabl_ctrl.sv -----
// Sequencer for loads, queries and the clearing pass after reset.
// Depends on lcabl_pkg; drives lcabl_dpath by command struct.
`timescale 1ns / 1ps

module lcabl_ctrl #(
  parameter int LEVELS = lcabl_pkg::LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  lcabl_pkg::dp_stat_t stat,
  output lcabl_pkg::dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_CLR     = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_LD_CHK  = 12'b0000_0000_0100,
    S_LD_FILL = 12'b0000_0000_1000,
    S_LD_WR   = 12'b0000_0001_0000,
    S_Q_CHK   = 12'b0000_0010_0000,
    S_LIFT    = 12'b0000_0100_0000,
    S_LIFT_WT = 12'b0000_1000_0000,
    S_Q_CMP   = 12'b0001_0000_0000,
    S_CLIMB   = 12'b0010_0000_0000,
    S_FIN     = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  // Pick the next state and the datapath command
  always_comb begin
    state_next = state;
    cmd.op     = lcabl_pkg::OP_NONE;
    cmd.lvl    = lcabl_pkg::LV_HOLD;
    unique case (state)
      S_CLR: begin
        cmd.op = lcabl_pkg::OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = lcabl_pkg::OP_CAPTURE;
          state_next = stat.in_query ? S_Q_CHK : S_LD_CHK;
        end
      end
      S_LD_CHK: begin
        cmd.op = lcabl_pkg::OP_LD_CHK;
        if (stat.ld_skip || stat.ld_bad) begin
          state_next = S_DONE;
        end else if (LEVELS == 1) begin
          cmd.lvl = lcabl_pkg::LV_ZERO;
          state_next = S_LD_WR;
        end else begin
          cmd.lvl = lcabl_pkg::LV_ONE;
          state_next = S_LD_FILL;
        end
      end
      S_LD_FILL: begin
        cmd.op = lcabl_pkg::OP_LD_FILL;
        if (stat.lvl_last) begin
          cmd.lvl = lcabl_pkg::LV_ZERO;
          state_next = S_LD_WR;
        end else begin
          cmd.lvl = lcabl_pkg::LV_INC;
        end
      end
      S_LD_WR: begin
        cmd.op  = lcabl_pkg::OP_LD_WR;
        cmd.lvl = lcabl_pkg::LV_INC;
        if (stat.lvl_last) state_next = S_DONE;
      end
      S_Q_CHK: begin
        cmd.op  = lcabl_pkg::OP_Q_CHK;
        cmd.lvl = lcabl_pkg::LV_TOP;
        state_next = stat.q_bad ? S_DONE : S_LIFT;
      end
      S_LIFT: begin
        cmd.op = lcabl_pkg::OP_LIFT;
        if (stat.lift_need) begin
          state_next = S_LIFT_WT;
        end else if (stat.lvl_zero) begin
          state_next = S_Q_CMP;
        end else begin
          cmd.lvl = lcabl_pkg::LV_DEC;
        end
      end
      S_LIFT_WT: begin
        cmd.op = lcabl_pkg::OP_LIFT_WT;
        state_next = S_LIFT;
      end
      S_Q_CMP: begin
        cmd.op  = lcabl_pkg::OP_Q_CMP;
        cmd.lvl = lcabl_pkg::LV_TOP;
        state_next = stat.uv_eq ? S_DONE : S_CLIMB;
      end
      S_CLIMB: begin
        cmd.op = lcabl_pkg::OP_CLIMB;
        if (stat.lvl_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.lvl = lcabl_pkg::LV_DEC;
        end
      end
      S_FIN: begin
        cmd.op = lcabl_pkg::OP_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op = lcabl_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/lcabl_dpath.sv -----
// Datapath: node memories, ancestor table, lifting registers, output register.
// Depends on lcabl_pkg; commanded by lcabl_ctrl.
`timescale 1ns / 1ps

module lcabl_dpath #(
  parameter int MAX_NODES = lcabl_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lcabl_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lcabl_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lcabl_pkg::OUT_W-1:0] m_tdata,
  input  lcabl_pkg::dp_cmd_t          cmd,
  output lcabl_pkg::dp_stat_t         stat
);

  localparam int NW     = lcabl_pkg::NODE_W;
  localparam int AW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TW     = AW + LW;
  localparam int TDEPTH = MAX_NODES * (1 << LW);
  localparam int XW     = AW + NW;
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  // Node number to memory index, and range check
  function automatic logic [AW-1:0] to_idx(input logic [NW-1:0] n);
    logic [XW-1:0] ext;
    ext = {{AW{1'b0}}, n};
    return ext[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [NW-1:0] n);
    return ({{AW{1'b0}}, n} < XW'(MAX_NODES));
  endfunction

  // Input fields
  logic          in_opc;
  logic [NW-1:0] in_node, in_par, in_u, in_v;
  assign in_opc  = s_tdata[0];
  assign in_node = s_tdata[10:1];
  assign in_par  = s_tdata[20:11];
  assign in_u    = s_tdata[30:21];
  assign in_v    = s_tdata[40:31];

  // Working registers
  logic [NW-1:0]   node_r, par_r, u_r, v_r, diff, dep_r;
  logic            prev_z;
  logic [LW-1:0]   lvl;
  logic [AW-1:0]   clr_cnt;
  logic [NW-1:0]   row [LEVELS];
  logic [NW-1:0]   res_anc;
  logic [lcabl_pkg::STAT_W-1:0] res_st;

  // Memories
  logic          mark_mem  [MAX_NODES];
  logic [NW-1:0] depth_mem [MAX_NODES];
  logic [NW-1:0] anc_mem   [TDEPTH];

  logic          mk_a, mk_b;
  logic [NW-1:0] dp_a, dp_b, ta, tb;
  logic [AW-1:0] nd_addr_a, nd_addr_b;
  logic [TW-1:0] ta_addr, tb_addr;

  // Derived values
  logic [NW-1:0] fill_val, au, av, nu, nv, step;
  logic          u_ok, v_ok;

  assign fill_val = prev_z ? '0 : ta;
  assign au   = (u_r == '0) ? '0 : ta;
  assign av   = (v_r == '0) ? '0 : tb;
  assign nu   = (au != av) ? au : u_r;
  assign nv   = (au != av) ? av : v_r;
  assign step = NW'(1) << lvl;
  assign u_ok = (u_r != '0) && in_range(u_r) && mk_a;
  assign v_ok = (v_r != '0) && in_range(v_r) && mk_b;

  // Status back to the sequencer
  always_comb begin
    stat.clr_last  = (clr_cnt == AW'(MAX_NODES - 1));
    stat.in_query  = (in_opc == lcabl_pkg::OPC_QUERY);
    stat.ld_skip   = (node_r == '0) || !in_range(node_r);
    stat.ld_bad    = (par_r != '0) && !(in_range(par_r) && mk_a);
    stat.q_bad     = !(u_ok && v_ok);
    stat.lift_need = ((diff >> lvl) != '0);
    stat.lvl_zero  = (lvl == '0);
    stat.lvl_last  = (lvl == LVL_TOP);
    stat.uv_eq     = (u_r == v_r);
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Node memory read addresses come straight from the offered item
  assign nd_addr_a = to_idx((in_opc == lcabl_pkg::OPC_QUERY) ? in_u : in_par);
  assign nd_addr_b = to_idx(in_v);

  // Ancestor table read addresses
  always_comb begin
    ta_addr = '0;
    tb_addr = '0;
    unique case (cmd.op)
      lcabl_pkg::OP_LD_CHK:  ta_addr = {to_idx(par_r), LW'(0)};
      lcabl_pkg::OP_LD_FILL: ta_addr = {to_idx(fill_val), lvl};
      lcabl_pkg::OP_LIFT:    ta_addr = {to_idx(u_r), lvl};
      lcabl_pkg::OP_Q_CMP: begin
        ta_addr = {to_idx(u_r), LVL_TOP};
        tb_addr = {to_idx(v_r), LVL_TOP};
      end
      lcabl_pkg::OP_CLIMB: begin
        ta_addr = {to_idx(nu), stat.lvl_zero ? LW'(0) : lvl - 1'b1};
        tb_addr = {to_idx(nv), lvl - 1'b1};
      end
      default: begin
        ta_addr = '0;
        tb_addr = '0;
      end
    endcase
  end

  // Node memories: clear or load write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.op == lcabl_pkg::OP_CLEAR) begin
      mark_mem[clr_cnt] <= 1'b0;
    end else if (cmd.op == lcabl_pkg::OP_LD_WR && lvl == '0) begin
      mark_mem[to_idx(node_r)]  <= 1'b1;
      depth_mem[to_idx(node_r)] <= dep_r;
    end
    mk_a <= mark_mem[nd_addr_a];
    mk_b <= mark_mem[nd_addr_b];
    dp_a <= depth_mem[nd_addr_a];
    dp_b <= depth_mem[nd_addr_b];
  end

  // Ancestor table: row write-out, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.op == lcabl_pkg::OP_LD_WR) begin
      anc_mem[{to_idx(node_r), lvl}] <= row[lvl];
    end
    ta <= anc_mem[ta_addr];
    tb <= anc_mem[tb_addr];
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      lvl     <= '0;
    end else begin
      if (cmd.op == lcabl_pkg::OP_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      unique case (cmd.lvl)
        lcabl_pkg::LV_HOLD: lvl <= lvl;
        lcabl_pkg::LV_TOP:  lvl <= LVL_TOP;
        lcabl_pkg::LV_ONE:  lvl <= LW'(1);
        lcabl_pkg::LV_ZERO: lvl <= '0;
        lcabl_pkg::LV_INC:  lvl <= lvl + 1'b1;
        lcabl_pkg::LV_DEC:  lvl <= lvl - 1'b1;
        default:            lvl <= lvl;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      lcabl_pkg::OP_CAPTURE: begin
        node_r <= in_node;
        par_r  <= in_par;
        u_r    <= in_u;
        v_r    <= in_v;
      end
      lcabl_pkg::OP_LD_CHK: begin
        res_anc <= '0;
        res_st  <= (stat.ld_bad && !stat.ld_skip) ? lcabl_pkg::ST_BAD_PARENT
                                                  : lcabl_pkg::ST_OK;
        dep_r   <= (par_r == '0) ? '0 :
                   (dp_a == lcabl_pkg::DEPTH_MAX) ? dp_a : dp_a + 1'b1;
        row[0]  <= par_r;
        prev_z  <= (par_r == '0);
      end
      lcabl_pkg::OP_LD_FILL: begin
        row[lvl] <= fill_val;
        prev_z   <= (fill_val == '0);
      end
      lcabl_pkg::OP_Q_CHK: begin
        res_anc <= '0;
        res_st  <= stat.q_bad ? lcabl_pkg::ST_BAD_QUERY : lcabl_pkg::ST_OK;
        // keep the deeper node in u_r
        if (dp_a < dp_b) begin
          u_r  <= v_r;
          v_r  <= u_r;
          diff <= dp_b - dp_a;
        end else begin
          diff <= dp_a - dp_b;
        end
      end
      lcabl_pkg::OP_LIFT_WT: begin
        u_r  <= au;
        diff <= diff - step;
      end
      lcabl_pkg::OP_Q_CMP: begin
        if (stat.uv_eq) res_anc <= u_r;
      end
      lcabl_pkg::OP_CLIMB: begin
        u_r <= nu;
        v_r <= nv;
      end
      lcabl_pkg::OP_FIN: begin
        res_anc <= au;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == lcabl_pkg::OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lcabl_pkg::OP_EMIT) begin
      m_tdata <= {{(lcabl_pkg::OUT_W - NW - lcabl_pkg::STAT_W){1'b0}}, res_st, res_anc};
    end
  end

`ifndef ASSERT_OFF
  // A lift step is taken only while the depth gap still covers it
  a_lift_gap: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lcabl_pkg::OP_LIFT_WT |-> diff >= step)
    else $error("lift step beyond remaining depth gap");

  // Never emit an unused status code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lcabl_pkg::OP_EMIT |-> res_st <= lcabl_pkg::ST_BAD_QUERY)
    else $error("unused status code emitted");

  // Error results carry no ancestor
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lcabl_pkg::OP_EMIT && res_st != lcabl_pkg::ST_OK |-> res_anc == '0)
    else $error("error result with nonzero ancestor");

  // The clearing pass never overlaps a table write
  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lcabl_pkg::OP_CLEAR |=> cmd.op == lcabl_pkg::OP_CLEAR ||
                                      cmd.op == lcabl_pkg::OP_NONE ||
                                      cmd.op == lcabl_pkg::OP_CAPTURE)
    else $error("clearing pass interrupted");
`endif

endmodule

// ----- sv/tree_lca_binary_lifting.sv -----
// Top level: lowest common ancestor by binary lifting over a loaded tree.
// Depends on lcabl_pkg, lcabl_ctrl and lcabl_dpath.
//
//   channel  dir  bits  contents
//   s_*      in   48    load (node, parent) or query (u, v)
//   m_*      out  16    ancestor and status, one per input item
//
// After reset the loaded marks are swept with s_tready low.
// A load takes one ancestor table read per level,
// then one table write per level. A query checks both nodes, lifts the deeper
// one down the levels, compares, then climbs both nodes down the levels.
// One item is worked at a time; a held result in the output register does not
// block acceptance of the next item, only its completion.
`timescale 1ns / 1ps

module tree_lca_binary_lifting #(
  parameter int MAX_NODES = lcabl_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lcabl_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // opcode[0], node_id[10:1], parent_node[20:11], query_u[30:21],
  // query_v[40:31], zero[47:41]
  input  logic [lcabl_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // ancestor[9:0], status[11:10], zero[15:12]
  output logic [lcabl_pkg::OUT_W-1:0] m_tdata
);

  lcabl_pkg::dp_cmd_t  cmd;
  lcabl_pkg::dp_stat_t stat;

  lcabl_ctrl #(
    .LEVELS(LEVELS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lcabl_dpath #(
    .MAX_NODES(MAX_NODES),
    .LEVELS   (LEVELS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

// ----- verif/tb_tree_lca_binary_lifting.sv -----
// Testbench for tree_lca_binary_lifting: streams node loads and common-ancestor
// queries, predicts each result with a behavioral tree model, and checks them in order.
// Depends on lcabl_pkg and the tree_lca_binary_lifting RTL.
`timescale 1ns / 1ps

module tb_tree_lca_binary_lifting;

  localparam int NN = lcabl_pkg::MAX_NODES_DEF;
  localparam int LV = lcabl_pkg::LEVELS_DEF;
  localparam int NW = lcabl_pkg::NODE_W;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [NW-1:0]                anc;
    logic [lcabl_pkg::STAT_W-1:0] st;
  } lca_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [lcabl_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [lcabl_pkg::OUT_W-1:0] m_tdata;

  // Shadow tree state
  logic [NW-1:0] tree_depth [NN];
  logic [NW-1:0] tree_up [NN][LV];
  bit            tree_loaded [NN];

  lca_result_t pending_results[$];
  int  error_count = 0;
  int  rx_wait = 0;
  longint cycle_count = 0;

  tree_lca_binary_lifting u_top (.*);

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [NW-1:0] up_of(int n, int j);
    if (n == 0 || n >= NN || j >= LV) return '0;
    return tree_up[n][j];
  endfunction

  function automatic bit present(int n);
    return n != 0 && n < NN && tree_loaded[n];
  endfunction

  // Predict the result of one item and update the shadow tree
  function automatic lca_result_t predict_lca(logic [lcabl_pkg::IN_W-1:0] item);
    lca_result_t r;
    int node, par, u, v, du, dv, t, d;
    logic [NW-1:0] row [LV];
    logic [NW-1:0] au, av;
    r = '0;
    if (item[0] == lcabl_pkg::OPC_LOAD) begin
      node = int'(item[10:1]);
      par  = int'(item[20:11]);
      if (node != 0) begin
        if (par != 0 && !present(par)) begin
          r.st = lcabl_pkg::ST_BAD_PARENT;
        end else begin
          d = 0;
          if (par != 0) begin
            d = int'(tree_depth[par]) + 1;
            if (d > int'(lcabl_pkg::DEPTH_MAX)) d = int'(lcabl_pkg::DEPTH_MAX);
          end
          row[0] = NW'(par);
          for (int j = 1; j < LV; j++) row[j] = up_of(int'(row[j-1]), j - 1);
          for (int j = 0; j < LV; j++) tree_up[node][j] = row[j];
          tree_depth[node] = NW'(d);
          tree_loaded[node] = 1'b1;
        end
      end
    end else begin
      u = int'(item[30:21]);
      v = int'(item[40:31]);
      if (!present(u) || !present(v)) begin
        r.st = lcabl_pkg::ST_BAD_QUERY;
      end else begin
        du = int'(tree_depth[u]);
        dv = int'(tree_depth[v]);
        if (du < dv) begin
          t = u; u = v; v = t;
          t = du; du = dv; dv = t;
        end
        d = du - dv;
        for (int j = LV - 1; j >= 0; j--) begin
          while (d >= (1 << j)) begin
            u = int'(up_of(u, j));
            d -= (1 << j);
          end
        end
        if (u == v) begin
          r.anc = NW'(u);
        end else begin
          for (int j = LV - 1; j >= 0; j--) begin
            au = up_of(u, j);
            av = up_of(v, j);
            if (au != av) begin
              u = int'(au);
              v = int'(av);
            end
          end
          r.anc = up_of(u, 0);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [lcabl_pkg::IN_W-1:0] load_item(int node, int par, int junk = 0);
    logic [lcabl_pkg::IN_W-1:0] w;
    w = '0;
    w[0] = lcabl_pkg::OPC_LOAD;
    w[10:1] = NW'(node);
    w[20:11] = NW'(par);
    w[40:21] = 20'(junk);
    return w;
  endfunction

  function automatic logic [lcabl_pkg::IN_W-1:0] query_item(int u, int v, int junk = 0);
    logic [lcabl_pkg::IN_W-1:0] w;
    w = '0;
    w[0] = lcabl_pkg::OPC_QUERY;
    w[20:1] = 20'(junk);
    w[30:21] = NW'(u);
    w[40:31] = NW'(v);
    return w;
  endfunction

  // Send one item after a random gap; hold it until the transfer
  task automatic send_item(logic [lcabl_pkg::IN_W-1:0] item);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results = {pending_results, predict_lca(item)};
  endtask

  // Receiver draws a random wait before taking each result, counted down while a result is held
  always @(posedge clk) begin
    int draw;
    draw = $urandom_range(0, 7);
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= draw;
    end else if (m_tvalid && m_tready) begin
      m_tready <= (draw == 0);
      rx_wait  <= draw;
    end else if (m_tvalid && !m_tready) begin
      if (rx_wait == 0) m_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    lca_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[9:0] !== want.anc) begin
          $display("%0t: ancestor expected %0d actual %0d", $time, want.anc, m_tdata[9:0]);
          error_count++;
        end
        if (m_tdata[11:10] !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, m_tdata[11:10]);
          error_count++;
        end
        if (m_tdata[15:12] !== 4'd0) begin
          $display("%0t: pad expected 0 actual %h", $time, m_tdata[15:12]);
          error_count++;
        end
      end
    end
  end

  // Drop the input and wait until every expected result has come
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extremes, errors and special cases
  task automatic test_directed();
    send_item(query_item(1, 1));            // unloaded query
    send_item(load_item(0, 5));              // node zero ignored
    send_item(load_item(1, 0, 20'hfffff));   // root, junk in unused fields
    send_item(load_item(2, 1));
    send_item(load_item(3, 1));
    send_item(load_item(4, 2));
    send_item(load_item(1023, 4));
    send_item(load_item(5, 1023));
    send_item(load_item(6, 1000));           // unloaded parent
    send_item(query_item(1023, 3, 20'hfffff));
    send_item(query_item(5, 4));
    send_item(query_item(4, 4));
    send_item(query_item(0, 4));
    send_item(query_item(4, 1000));
    send_item(load_item(900, 0));            // second root
    send_item(query_item(900, 5));           // different trees
    send_item(load_item(5, 5));              // self parent reload
    send_item(query_item(5, 2));
    send_item(load_item(2, 900));            // reload moves subtree root
    send_item(query_item(4, 900));
    send_item(query_item(1023, 1));
    drain_results();
  endtask

  // Long chain to exercise deep lifting
  task automatic test_deep_chain();
    send_item(load_item(10, 0));
    for (int n = 11; n < 40; n++) send_item(load_item(n, n - 1));
    send_item(query_item(39, 10));
    send_item(query_item(25, 39));
    send_item(load_item(700, 700));          // unloaded self parent
    drain_results();
  endtask

  function automatic int pick_loaded();
    int n;
    for (int k = 0; k < 50; k++) begin
      n = $urandom_range(1, NN - 1);
      if (tree_loaded[n]) return n;
    end
    return 10;
  endfunction

  // Random growth of trees mixed with queries and noise
  task automatic test_random(int count);
    int n, p, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        n = $urandom_range(1, NN - 1);
        p = ($urandom_range(0, 19) == 0) ? 0 : pick_loaded();
        send_item(load_item(n, p, int'($urandom)));
      end else if (sel < 85) begin
        send_item(query_item(pick_loaded(), pick_loaded(), int'($urandom)));
      end else if (sel < 93) begin
        send_item(query_item($urandom_range(0, NN - 1), $urandom_range(0, NN - 1),
                             int'($urandom)));
      end else begin
        send_item(load_item($urandom_range(0, NN - 1), $urandom_range(0, NN - 1),
                            int'($urandom)));
      end
      if (i == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    for (int n = 0; n < NN; n++) tree_loaded[n] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_deep_chain();
    test_random(760);
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/lcabl_pkg.sv
sv/lcabl_ctrl.sv
sv/lcabl_dpath.sv
sv/tree_lca_binary_lifting.sv
verif/tb_tree_lca_binary_lifting.sv
